[hdl/rsa_pkg.sv]
package rsa_pkg;

    // default sizing
    localparam int DEF_MAX_ROWS   = 1024;
    localparam int DEF_SEAT_WIDTH = 20;

    // port field widths
    localparam int COUNT_W    = 30;
    localparam int ROW_W      = 10;
    localparam int SEAT_W     = 20;
    localparam int NUM_ROWS_W = 11;
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;

    // register indexes
    localparam logic REG_NUM_ROWS      = 1'b0;
    localparam logic REG_SEATS_PER_ROW = 1'b1;

    // datapath commands
    typedef logic [4:0] op_t;
    localparam op_t OP_IDLE      = 5'd0;
    localparam op_t OP_CLEAR     = 5'd1;
    localparam op_t OP_LOAD      = 5'd2;
    localparam op_t OP_G_START   = 5'd3;
    localparam op_t OP_G_DESC_RD = 5'd4;
    localparam op_t OP_G_DESC_CK = 5'd5;
    localparam op_t OP_LEAF_RD   = 5'd6;
    localparam op_t OP_G_LEAF    = 5'd7;
    localparam op_t OP_UP_RD     = 5'd8;
    localparam op_t OP_UP_WR     = 5'd9;
    localparam op_t OP_S_START   = 5'd10;
    localparam op_t OP_RS_A_RD   = 5'd11;
    localparam op_t OP_RS_A_ADD  = 5'd12;
    localparam op_t OP_RS_B_RD   = 5'd13;
    localparam op_t OP_RS_B_ADD  = 5'd14;
    localparam op_t OP_RS_SHIFT  = 5'd15;
    localparam op_t OP_RS_DONE   = 5'd16;
    localparam op_t OP_S_RD      = 5'd17;
    localparam op_t OP_S_ROW     = 5'd18;
    localparam op_t OP_OUT       = 5'd19;

    // datapath status towards the controller
    typedef struct packed {
        logic clr_last;
        logic kind;
        logic k_gt_cap;
        logic min_gt_t;
        logic at_leaf;
        logic r_gt_maxr;
        logic up_last;
        logic open_gt_max;
        logic k_zero;
        logic a_gt_b;
        logic a_odd;
        logic b_even;
        logic free_lt_k;
        logic row_stop;
        logic out_busy;
    } dp_status_t;

endpackage

[hdl/rsa_ctrl.sv]
module rsa_ctrl
    import rsa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr,
    input  logic       req_valid,
    output logic       req_ready,
    input  dp_status_t status,
    output op_t        cmd
);

    localparam logic [4:0] ST_CLEAR     = 5'd0;
    localparam logic [4:0] ST_IDLE      = 5'd1;
    localparam logic [4:0] ST_DISPATCH  = 5'd2;
    localparam logic [4:0] ST_G_ROOT    = 5'd3;
    localparam logic [4:0] ST_G_DESC_RD = 5'd4;
    localparam logic [4:0] ST_G_DESC_CK = 5'd5;
    localparam logic [4:0] ST_G_LEAF_RD = 5'd6;
    localparam logic [4:0] ST_G_LEAF    = 5'd7;
    localparam logic [4:0] ST_UP_RD     = 5'd8;
    localparam logic [4:0] ST_UP_WR     = 5'd9;
    localparam logic [4:0] ST_SC_CHK    = 5'd10;
    localparam logic [4:0] ST_RS_A      = 5'd11;
    localparam logic [4:0] ST_RS_AW     = 5'd12;
    localparam logic [4:0] ST_RS_B      = 5'd13;
    localparam logic [4:0] ST_RS_BW     = 5'd14;
    localparam logic [4:0] ST_RS_SH     = 5'd15;
    localparam logic [4:0] ST_RS_DONE   = 5'd16;
    localparam logic [4:0] ST_SC_RD     = 5'd17;
    localparam logic [4:0] ST_SC_ROW    = 5'd18;
    localparam logic [4:0] ST_FINISH    = 5'd19;

    logic [4:0] state_reg;
    logic [4:0] state_next;

    assign req_ready = (state_reg == ST_IDLE);

    // sequencing of tree walks
    always_comb
    begin
        state_next = state_reg;
        cmd        = OP_IDLE;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd = OP_CLEAR;
                if (status.clr_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd        = OP_LOAD;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                if (!status.kind)
                begin
                    cmd        = OP_G_START;
                    state_next = status.k_gt_cap ? ST_FINISH : ST_G_ROOT;
                end
                else
                begin
                    cmd        = OP_S_START;
                    state_next = status.open_gt_max ? ST_FINISH : ST_RS_A;
                end
            end
            ST_G_ROOT:
                state_next = status.min_gt_t ? ST_FINISH : ST_G_DESC_RD;
            ST_G_DESC_RD:
            begin
                cmd        = OP_G_DESC_RD;
                state_next = ST_G_DESC_CK;
            end
            ST_G_DESC_CK:
            begin
                cmd        = OP_G_DESC_CK;
                state_next = status.at_leaf ? ST_G_LEAF_RD : ST_G_DESC_RD;
            end
            ST_G_LEAF_RD:
            begin
                cmd        = OP_LEAF_RD;
                state_next = ST_G_LEAF;
            end
            ST_G_LEAF:
            begin
                if (status.r_gt_maxr)
                    state_next = ST_FINISH;
                else
                begin
                    cmd        = OP_G_LEAF;
                    state_next = ST_UP_RD;
                end
            end
            ST_UP_RD:
            begin
                cmd        = OP_UP_RD;
                state_next = ST_UP_WR;
            end
            ST_UP_WR:
            begin
                cmd = OP_UP_WR;
                if (status.up_last)
                    state_next = status.kind ? ST_SC_CHK : ST_FINISH;
                else
                    state_next = ST_UP_RD;
            end
            ST_SC_CHK:
                state_next = status.row_stop ? ST_FINISH : ST_SC_RD;
            ST_RS_A:
            begin
                if (status.a_gt_b)
                    state_next = ST_RS_DONE;
                else if (status.a_odd)
                begin
                    cmd        = OP_RS_A_RD;
                    state_next = ST_RS_AW;
                end
                else
                    state_next = ST_RS_B;
            end
            ST_RS_AW:
            begin
                cmd        = OP_RS_A_ADD;
                state_next = ST_RS_B;
            end
            ST_RS_B:
            begin
                if (status.b_even)
                begin
                    cmd        = OP_RS_B_RD;
                    state_next = ST_RS_BW;
                end
                else
                    state_next = ST_RS_SH;
            end
            ST_RS_BW:
            begin
                cmd        = OP_RS_B_ADD;
                state_next = ST_RS_SH;
            end
            ST_RS_SH:
            begin
                cmd        = OP_RS_SHIFT;
                state_next = ST_RS_A;
            end
            ST_RS_DONE:
            begin
                cmd = OP_RS_DONE;
                if (status.free_lt_k || status.k_zero)
                    state_next = ST_FINISH;
                else
                    state_next = ST_SC_RD;
            end
            ST_SC_RD:
            begin
                cmd        = OP_S_RD;
                state_next = ST_SC_ROW;
            end
            ST_SC_ROW:
            begin
                cmd        = OP_S_ROW;
                state_next = ST_UP_RD;
            end
            ST_FINISH:
            begin
                if (!status.out_busy)
                begin
                    cmd        = OP_OUT;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_CLEAR;
        endcase
        if (cfg_wr)
            state_next = ST_CLEAR;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_CLEAR;
        else
            state_reg <= state_next;
    end

endmodule

[hdl/rsa_datapath.sv]
module rsa_datapath
    import rsa_pkg::*;
#(
    parameter int MAX_ROWS   = DEF_MAX_ROWS,
    parameter int SEAT_WIDTH = DEF_SEAT_WIDTH
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  op_t                         cmd,
    input  logic                        cfg_wr,
    input  logic [$clog2(MAX_ROWS):0]   n_eff,
    input  logic [SEAT_WIDTH-1:0]       cap,
    input  logic                        kind,
    input  logic [COUNT_W-1:0]          seat_count,
    input  logic [ROW_W-1:0]            last_row,
    input  logic                        rsp_ready,
    output logic                        rsp_valid,
    output logic                        granted,
    output logic [ROW_W-1:0]            row_index,
    output logic [SEAT_W-1:0]           first_seat,
    output dp_status_t                  status
);

    localparam int LOG  = $clog2(MAX_ROWS);
    localparam int HW   = LOG + 1;
    localparam int SUMW = LOG + SEAT_WIDTH;
    localparam int MW   = SEAT_WIDTH + SUMW;
    localparam int CMPW = (COUNT_W > SUMW) ? COUNT_W : SUMW;
    localparam int XW   = LOG + ROW_W + 1;
    localparam int SXW  = SEAT_WIDTH + SEAT_W;
    localparam int DEPTH = 2 * MAX_ROWS;

    // tree store: heap index 1 is the root, leaves from MAX_ROWS up
    logic [MW-1:0] mem [DEPTH];
    logic [MW-1:0] rdata_reg;
    logic [HW-1:0] raddr;
    logic          mem_we;
    logic [HW-1:0] waddr;
    logic [MW-1:0] wdata;

    logic [SEAT_WIDTH-1:0] rd_min;
    logic [SUMW-1:0]       rd_sum;

    // control registers
    logic [HW-1:0]   clr_idx_reg,  clr_idx_next;
    logic [HW-1:0]   clr_lo_reg,   clr_lo_next;
    logic [HW-1:0]   clr_span_reg, clr_span_next;
    logic [HW-1:0]   lowest_reg,   lowest_next;
    logic            out_valid_reg, out_valid_next;

    // payload registers
    logic                  kind_reg,   kind_next;
    logic [COUNT_W-1:0]    k_reg,      k_next;
    logic [LOG-1:0]        maxr_reg,   maxr_next;
    logic [SEAT_WIDTH-1:0] t_reg,      t_next;
    logic [HW-1:0]         idx_reg,    idx_next;
    logic [SEAT_WIDTH-1:0] cur_min_reg, cur_min_next;
    logic [SUMW-1:0]       cur_sum_reg, cur_sum_next;
    logic [HW:0]           a_reg,      a_next;
    logic [HW:0]           b_reg,      b_next;
    logic [SUMW-1:0]       acc_reg,    acc_next;
    logic [SUMW-1:0]       prod_reg,   prod_next;
    logic [HW-1:0]         i_reg,      i_next;
    logic                  res_granted_reg, res_granted_next;
    logic [LOG-1:0]        res_row_reg, res_row_next;
    logic [SEAT_WIDTH-1:0] res_seat_reg, res_seat_next;
    logic                  out_granted_reg, out_granted_next;
    logic [ROW_W-1:0]      out_row_reg, out_row_next;
    logic [SEAT_W-1:0]     out_seat_reg, out_seat_next;

    // helpers
    logic [HW:0]             clr_end;
    logic [HW:0]             n_x;
    logic [HW-1:0]           clr_cnt;
    logic [SEAT_WIDTH+HW-1:0] clr_prod;
    logic [SEAT_WIDTH-1:0]   clr_min;
    logic [XW-1:0]           last_x;
    logic [XW-1:0]           nm1_x;
    logic [HW-1:0]           span_rows;
    logic [SEAT_WIDTH+HW-1:0] span_prod;
    logic [SEAT_WIDTH-1:0]   leaf_new;
    logic [SEAT_WIDTH-1:0]   row_free;
    logic [SUMW-1:0]         free_sum;
    logic [XW-1:0]           row_x;
    logic [SXW-1:0]          seat_x;
    logic [HW-1:0]           leaf_i;

    assign rd_min = rdata_reg[SUMW +: SEAT_WIDTH];
    assign rd_sum = rdata_reg[SUMW-1:0];

    // clearing pass node value from its row span
    assign clr_end  = {1'b0, clr_lo_reg} + {1'b0, clr_span_reg};
    assign n_x      = {1'b0, n_eff};
    assign clr_min  = ({1'b0, clr_lo_reg} >= n_x) ? cap : '0;
    always_comb
    begin
        if ({1'b0, clr_lo_reg} >= n_x)
            clr_cnt = clr_span_reg;
        else if (clr_end <= n_x)
            clr_cnt = '0;
        else
            clr_cnt = HW'(clr_end - n_x);
    end
    assign clr_prod = cap * clr_cnt;

    assign last_x    = XW'(last_row);
    assign nm1_x     = XW'(n_eff) - XW'(1);
    assign span_rows = HW'(maxr_reg) - lowest_reg + HW'(1);
    assign span_prod = span_rows * cap;
    assign leaf_new  = rd_min + SEAT_WIDTH'(k_reg);
    assign row_free  = cap - rd_min;
    assign free_sum  = prod_reg - acc_reg;
    assign row_x     = XW'(res_row_reg);
    assign seat_x    = SXW'(res_seat_reg);
    assign leaf_i    = {1'b1, i_reg[LOG-1:0]};

    // status towards the controller
    always_comb
    begin
        status.clr_last    = (clr_idx_reg == HW'(1));
        status.kind        = kind_reg;
        status.k_gt_cap    = (CMPW'(k_reg) > CMPW'(cap));
        status.min_gt_t    = (rd_min > t_reg);
        status.at_leaf     = idx_reg[LOG];
        status.r_gt_maxr   = (idx_reg[LOG-1:0] > maxr_reg);
        status.up_last     = (idx_reg[HW-1:1] == LOG'(1));
        status.open_gt_max = (lowest_reg > HW'(maxr_reg));
        status.k_zero      = (k_reg == '0);
        status.a_gt_b      = (a_reg > b_reg);
        status.a_odd       = a_reg[0];
        status.b_even      = !b_reg[0];
        status.free_lt_k   = (CMPW'(free_sum) < CMPW'(k_reg));
        status.row_stop    = (k_reg == '0) || (i_reg > HW'(maxr_reg));
        status.out_busy    = out_valid_reg && !rsp_ready;
    end

    // command decode
    always_comb
    begin
        clr_idx_next     = clr_idx_reg;
        clr_lo_next      = clr_lo_reg;
        clr_span_next    = clr_span_reg;
        lowest_next      = lowest_reg;
        out_valid_next   = out_valid_reg && !rsp_ready;
        kind_next        = kind_reg;
        k_next           = k_reg;
        maxr_next        = maxr_reg;
        t_next           = t_reg;
        idx_next         = idx_reg;
        cur_min_next     = cur_min_reg;
        cur_sum_next     = cur_sum_reg;
        a_next           = a_reg;
        b_next           = b_reg;
        acc_next         = acc_reg;
        prod_next        = prod_reg;
        i_next           = i_reg;
        res_granted_next = res_granted_reg;
        res_row_next     = res_row_reg;
        res_seat_next    = res_seat_reg;
        out_granted_next = out_granted_reg;
        out_row_next     = out_row_reg;
        out_seat_next    = out_seat_reg;
        raddr            = idx_reg;
        mem_we           = 1'b0;
        waddr            = idx_reg;
        wdata            = {cur_min_reg, cur_sum_reg};
        unique case (cmd)
            OP_IDLE:
            begin
            end
            OP_CLEAR:
            begin
                mem_we       = 1'b1;
                waddr        = clr_idx_reg;
                wdata        = {clr_min, clr_prod[SUMW-1:0]};
                clr_idx_next = clr_idx_reg - HW'(1);
                if (clr_lo_reg == '0)
                begin
                    clr_span_next = clr_span_reg << 1;
                    clr_lo_next   = HW'(MAX_ROWS) - (clr_span_reg << 1);
                end
                else
                    clr_lo_next = clr_lo_reg - clr_span_reg;
            end
            OP_LOAD:
            begin
                kind_next        = kind;
                k_next           = seat_count;
                maxr_next        = (last_x > nm1_x) ? nm1_x[LOG-1:0] : last_x[LOG-1:0];
                res_granted_next = 1'b0;
                res_row_next     = '0;
                res_seat_next    = '0;
            end
            OP_G_START:
            begin
                t_next   = cap - SEAT_WIDTH'(k_reg);
                idx_next = HW'(1);
                raddr    = HW'(1);
            end
            OP_G_DESC_RD:
            begin
                idx_next = idx_reg << 1;
                raddr    = idx_reg << 1;
            end
            OP_G_DESC_CK:
            begin
                if (rd_min > t_reg)
                    idx_next = idx_reg + HW'(1);
            end
            OP_LEAF_RD:
                raddr = idx_reg;
            OP_G_LEAF:
            begin
                res_granted_next = 1'b1;
                res_row_next     = idx_reg[LOG-1:0];
                res_seat_next    = rd_min;
                mem_we           = 1'b1;
                waddr            = idx_reg;
                wdata            = {leaf_new, SUMW'(leaf_new)};
                cur_min_next     = leaf_new;
                cur_sum_next     = SUMW'(leaf_new);
                if ((lowest_reg == HW'(idx_reg[LOG-1:0])) && (leaf_new == cap))
                    lowest_next = lowest_reg + HW'(1);
            end
            OP_UP_RD:
                raddr = {idx_reg[HW-1:1], ~idx_reg[0]};
            OP_UP_WR:
            begin
                mem_we       = 1'b1;
                waddr        = {1'b0, idx_reg[HW-1:1]};
                cur_min_next = (cur_min_reg < rd_min) ? cur_min_reg : rd_min;
                cur_sum_next = cur_sum_reg + rd_sum;
                wdata        = {cur_min_next, cur_sum_next};
                idx_next     = {1'b0, idx_reg[HW-1:1]};
            end
            OP_S_START:
            begin
                if (lowest_reg > HW'(maxr_reg))
                    res_granted_next = (k_reg == '0);
                a_next    = {2'b01, lowest_reg[LOG-1:0]};
                b_next    = {2'b01, maxr_reg};
                acc_next  = '0;
                prod_next = span_prod[SUMW-1:0];
            end
            OP_RS_A_RD:
                raddr = a_reg[HW-1:0];
            OP_RS_A_ADD:
            begin
                acc_next = acc_reg + rd_sum;
                a_next   = a_reg + (HW+1)'(1);
            end
            OP_RS_B_RD:
                raddr = b_reg[HW-1:0];
            OP_RS_B_ADD:
            begin
                acc_next = acc_reg + rd_sum;
                b_next   = b_reg - (HW+1)'(1);
            end
            OP_RS_SHIFT:
            begin
                a_next = a_reg >> 1;
                b_next = b_reg >> 1;
            end
            OP_RS_DONE:
            begin
                res_granted_next = !(CMPW'(free_sum) < CMPW'(k_reg));
                i_next           = lowest_reg;
            end
            OP_S_RD:
                raddr = leaf_i;
            OP_S_ROW:
            begin
                mem_we   = 1'b1;
                waddr    = leaf_i;
                idx_next = leaf_i;
                if (CMPW'(row_free) > CMPW'(k_reg))
                begin
                    cur_min_next = leaf_new;
                    k_next       = '0;
                end
                else
                begin
                    cur_min_next = cap;
                    k_next       = k_reg - COUNT_W'(row_free);
                    lowest_next  = lowest_reg + HW'(1);
                    i_next       = i_reg + HW'(1);
                end
                cur_sum_next = SUMW'(cur_min_next);
                wdata        = {cur_min_next, cur_sum_next};
            end
            OP_OUT:
            begin
                out_valid_next   = 1'b1;
                out_granted_next = res_granted_reg;
                out_row_next     = row_x[ROW_W-1:0];
                out_seat_next    = seat_x[SEAT_W-1:0];
            end
            default:
            begin
            end
        endcase
        // a register write restarts the clearing pass
        if (cfg_wr)
        begin
            clr_idx_next  = HW'(DEPTH - 1);
            clr_lo_next   = HW'(MAX_ROWS - 1);
            clr_span_next = HW'(1);
            lowest_next   = '0;
        end
    end

    // tree memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_idx_reg   <= HW'(DEPTH - 1);
            clr_lo_reg    <= HW'(MAX_ROWS - 1);
            clr_span_reg  <= HW'(1);
            lowest_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            clr_idx_reg   <= clr_idx_next;
            clr_lo_reg    <= clr_lo_next;
            clr_span_reg  <= clr_span_next;
            lowest_reg    <= lowest_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        kind_reg        <= kind_next;
        k_reg           <= k_next;
        maxr_reg        <= maxr_next;
        t_reg           <= t_next;
        idx_reg         <= idx_next;
        cur_min_reg     <= cur_min_next;
        cur_sum_reg     <= cur_sum_next;
        a_reg           <= a_next;
        b_reg           <= b_next;
        acc_reg         <= acc_next;
        prod_reg        <= prod_next;
        i_reg           <= i_next;
        res_granted_reg <= res_granted_next;
        res_row_reg     <= res_row_next;
        res_seat_reg    <= res_seat_next;
        out_granted_reg <= out_granted_next;
        out_row_reg     <= out_row_next;
        out_seat_reg    <= out_seat_next;
    end

    assign rsp_valid  = out_valid_reg;
    assign granted    = out_granted_reg;
    assign row_index  = out_row_reg;
    assign first_seat = out_seat_reg;

endmodule

[hdl/row_seat_first_fit_allocator.sv]
// Row seat allocator: hands out seats in equal rows, first fit.
// Request transactions (kind, seat_count, last_row) arrive on req_valid and
// req_ready; one response transaction (granted, row_index, first_seat) per
// request leaves on rsp_valid and rsp_ready, in request order.
// Registers num_rows and seats_per_row sit on the APB port at 0x0 and 0x4;
// writing either clears every seat count.
// One request is worked at a time; a tree of per-row counts lives in a
// memory with one write port and one registered read port.
// A gather walks the tree from acceptance to its response; a scatter first
// sums the free seats over the row range, then updates the tree for each
// row it fills.
// After reset, and after each register write, a clearing pass rebuilds the
// tree while req_ready stays low.
// The response sits in an output register; a stalled receiver holds it and
// the next request is worked meanwhile, waiting only to hand over its result.
module row_seat_first_fit_allocator
    import rsa_pkg::*;
#(
    parameter int MAX_ROWS   = DEF_MAX_ROWS,
    parameter int SEAT_WIDTH = DEF_SEAT_WIDTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_W-1:0]    paddr,
    input  logic [PDATA_W-1:0]    pwdata,
    output logic [PDATA_W-1:0]    prdata,
    output logic                  pready,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  logic                  kind,
    input  logic [COUNT_W-1:0]    seat_count,
    input  logic [ROW_W-1:0]      last_row,
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    output logic                  granted,
    output logic [ROW_W-1:0]      row_index,
    output logic [SEAT_W-1:0]     first_seat
);

    localparam int HW = $clog2(MAX_ROWS) + 1;
    localparam int TW = ((NUM_ROWS_W > HW) ? NUM_ROWS_W : HW) + 1;
    localparam int NW = (SEAT_W > SEAT_WIDTH) ? SEAT_W : SEAT_WIDTH;

    logic [NUM_ROWS_W-1:0] num_rows_reg;
    logic [SEAT_W-1:0]     seats_reg;
    logic                  cfg_wr;
    logic [TW-1:0]         num_x;
    logic [TW-1:0]         n_sat;
    logic [HW-1:0]         n_eff;
    logic [NW-1:0]         seats_x;
    logic [SEAT_WIDTH-1:0] cap;
    op_t                   cmd;
    dp_status_t            status;

    // register port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_rows_reg <= NUM_ROWS_W'(1024);
            seats_reg    <= SEAT_W'(1048575);
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_NUM_ROWS:      num_rows_reg <= pwdata[NUM_ROWS_W-1:0];
                REG_SEATS_PER_ROW: seats_reg    <= pwdata[SEAT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_NUM_ROWS:      prdata = PDATA_W'(num_rows_reg);
            REG_SEATS_PER_ROW: prdata = PDATA_W'(seats_reg);
            default:           prdata = '0;
        endcase
    end

    // effective row count and row capacity
    assign num_x = TW'(num_rows_reg);
    always_comb
    begin
        if (num_x == '0)
            n_sat = TW'(1);
        else if (num_x > TW'(MAX_ROWS))
            n_sat = TW'(MAX_ROWS);
        else
            n_sat = num_x;
    end
    assign n_eff   = n_sat[HW-1:0];
    assign seats_x = NW'(seats_reg);
    assign cap     = seats_x[SEAT_WIDTH-1:0];

    rsa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr    (cfg_wr),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .status    (status),
        .cmd       (cmd)
    );

    rsa_datapath #(
        .MAX_ROWS   (MAX_ROWS),
        .SEAT_WIDTH (SEAT_WIDTH)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .cfg_wr     (cfg_wr),
        .n_eff      (n_eff),
        .cap        (cap),
        .kind       (kind),
        .seat_count (seat_count),
        .last_row   (last_row),
        .rsp_ready  (rsp_ready),
        .rsp_valid  (rsp_valid),
        .granted    (granted),
        .row_index  (row_index),
        .first_seat (first_seat),
        .status     (status)
    );

endmodule
